[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define LBBE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication checked in the same cycle as its antecedent.
`define LBBE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/lbbe_pkg.sv]
// ----------------------------------------------------------------------------
// LED bar bit-plane encoder package
// Widths, codes, shared types and the bar intensity function.
// ----------------------------------------------------------------------------
package lbbe_pkg;

	localparam int PLANES     = 4;
	// Codes are four bits wide, so planes above the fourth would be all zero.
	localparam int PLANES_OUT = (PLANES > 4) ? 4 : PLANES;

	localparam int OP_W      = 2;
	localparam int VAL_W     = 8;
	localparam int COL_W     = 4;
	localparam int PLANE_W   = 2;
	localparam int WORD_W    = 16;
	localparam int CODE_W    = 4;
	localparam int POS_W     = 5;
	localparam int STEP_W    = 2;
	localparam int MAG_W     = VAL_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = CODE_W;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	typedef enum logic [OP_W-1:0] {
		OP_BAR16    = 2'd0,
		OP_SIGNED16 = 2'd1,
		OP_BAR32    = 2'd2,
		OP_NONE     = 2'd3
	} opcode_t;

	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_OFF      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LOW      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LOW_MID  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_HIGH_MID = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FULL     = 3'd4;

	localparam logic [CODE_W-1:0] RST_LEVEL_OFF      = 4'd0;
	localparam logic [CODE_W-1:0] RST_LEVEL_LOW      = 4'd2;
	localparam logic [CODE_W-1:0] RST_LEVEL_LOW_MID  = 4'd5;
	localparam logic [CODE_W-1:0] RST_LEVEL_HIGH_MID = 4'd9;
	localparam logic [CODE_W-1:0] RST_LEVEL_FULL     = 4'd15;

	typedef struct packed {
		logic [CODE_W-1:0] off;
		logic [CODE_W-1:0] low;
		logic [CODE_W-1:0] low_mid;
		logic [CODE_W-1:0] high_mid;
		logic [CODE_W-1:0] full;
	} levels_t;

	// One classified item as it waits between the front and the back.
	typedef struct packed {
		opcode_t            mode;
		logic               neg;
		logic [POS_W-1:0]   coarse;
		logic [STEP_W-1:0]  step;
		logic [COL_W-1:0]   col_first;
		logic [COL_W-1:0]   col_second;
		logic               same;
	} job_t;

	// Intensity code of bar position pos.
	function automatic logic [CODE_W-1:0] bar_code(
		input levels_t           lv,
		input logic [POS_W-1:0]  coarse,
		input logic [STEP_W-1:0] step,
		input logic [POS_W-1:0]  pos
	);
		logic [CODE_W-1:0] code;
		priority if (coarse > pos) begin
			code = lv.full;
		end else if (coarse < pos) begin
			code = lv.off;
		end else begin
			unique case (step)
				2'd0:    code = lv.off;
				2'd1:    code = lv.low;
				2'd2:    code = lv.low_mid;
				default: code = lv.high_mid;
			endcase
		end
		return code;
	endfunction

endpackage

[rtl/lbbe_in_if.sv]
// ----------------------------------------------------------------------------
// Input word channel
// Valid/ready channel that carries one bar request.
// ----------------------------------------------------------------------------
interface lbbe_in_if;
	logic                       valid;
	logic                       ready;
	logic [lbbe_pkg::OP_W-1:0]  opcode;
	logic [lbbe_pkg::VAL_W-1:0] bar_value;
	logic [lbbe_pkg::COL_W-1:0] column_first;
	logic [lbbe_pkg::COL_W-1:0] column_second;

	modport source (output valid, opcode, bar_value, column_first, column_second,
		input ready);
	modport sink (input valid, opcode, bar_value, column_first, column_second,
		output ready);
endinterface

[rtl/lbbe_out_if.sv]
// ----------------------------------------------------------------------------
// Output word channel
// Valid/ready channel that carries one bit-plane word.
// ----------------------------------------------------------------------------
interface lbbe_out_if;
	logic                         valid;
	logic                         ready;
	logic [lbbe_pkg::COL_W-1:0]   column;
	logic [lbbe_pkg::PLANE_W-1:0] plane;
	logic [lbbe_pkg::WORD_W-1:0]  plane_word;
	logic                         last;

	modport source (output valid, column, plane, plane_word, last, input ready);
	modport sink (input valid, column, plane, plane_word, last, output ready);
endinterface

[rtl/lbbe_front.sv]
// ----------------------------------------------------------------------------
// Front end
// Accepts request words, drops the unused opcode and reduces the level to a
// coarse position and a partial step for the selected mode.
// ----------------------------------------------------------------------------
module lbbe_front (
	lbbe_in_if.sink         items,
	input  logic            full,
	output logic            push,
	output lbbe_pkg::job_t  job
);

	lbbe_pkg::opcode_t              op;
	logic                           neg;
	logic [lbbe_pkg::MAG_W-1:0]     mag;

	assign op  = lbbe_pkg::opcode_t'(items.opcode);
	assign neg = items.bar_value[lbbe_pkg::VAL_W-1];
	// Magnitude of the two's complement value; the most negative level gives 128.
	assign mag = neg ? (lbbe_pkg::MAG_W'(1) << lbbe_pkg::VAL_W)
			- {1'b0, items.bar_value}
		: {1'b0, items.bar_value};

	assign items.ready = !full;
	assign push        = items.valid && !full && (op != lbbe_pkg::OP_NONE);

	always_comb begin
		job.mode       = op;
		job.neg        = neg;
		job.col_first  = items.column_first;
		job.col_second = items.column_second;
		job.same       = (items.column_first == items.column_second);
		unique case (op)
			lbbe_pkg::OP_BAR16: begin
				job.coarse = {1'b0, items.bar_value[7:4]};
				job.step   = items.bar_value[3:2];
			end
			lbbe_pkg::OP_SIGNED16: begin
				job.coarse = mag[8:4];
				job.step   = mag[3:2];
			end
			lbbe_pkg::OP_BAR32: begin
				job.coarse = items.bar_value[7:3];
				job.step   = items.bar_value[2:1];
			end
			default: begin
				job.coarse = '0;
				job.step   = '0;
			end
		endcase
	end

endmodule

[rtl/lbbe_queue.sv]
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out buffer of classified items between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbbe_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lbbe_pkg::job_t  push_job,
	input  logic            pop,
	output logic            full,
	output logic            nonempty,
	output lbbe_pkg::job_t  head
);

	lbbe_pkg::job_t                  entry_q [lbbe_pkg::QDEPTH];
	logic [lbbe_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [lbbe_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [lbbe_pkg::QCNT_W-1:0]     count_q;

	assign full     = (count_q == lbbe_pkg::QCNT_W'(lbbe_pkg::QDEPTH));
	assign nonempty = (count_q != '0);
	assign head     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == lbbe_pkg::QPTR_W'(lbbe_pkg::QDEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == lbbe_pkg::QPTR_W'(lbbe_pkg::QDEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`LBBE_ASSERT(a_count_bound, count_q <= lbbe_pkg::QCNT_W'(lbbe_pkg::QDEPTH), "queue overfilled")
	`LBBE_ASSERT_IMPL(a_pop_nonempty, pop, nonempty, "pop from an empty queue")
	`LBBE_ASSERT_IMPL(a_push_space, push && !pop, !full, "push into a full queue")

endmodule

[rtl/lbbe_back.sv]
// ----------------------------------------------------------------------------
// Back end
// Builds one bit-plane word per cycle from the job at the queue head, unless the
// output stalls, and holds it in the output register until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbbe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lbbe_pkg::levels_t levels,
	input  logic              nonempty,
	input  lbbe_pkg::job_t    head,
	output logic              pop,
	lbbe_out_if.source        words
);

	logic [lbbe_pkg::PLANE_W-1:0] plane_q;
	logic                         half_q;
	logic                         o_valid_q;
	logic [lbbe_pkg::COL_W-1:0]   o_column_q;
	logic [lbbe_pkg::PLANE_W-1:0] o_plane_q;
	logic [lbbe_pkg::WORD_W-1:0]  o_word_q;
	logic                         o_last_q;

	logic                         adv;
	logic                         plane_end;
	logic                         last_word;
	logic [lbbe_pkg::WORD_W-1:0]  word;

	assign adv       = nonempty && (!o_valid_q || words.ready);
	assign plane_end = (plane_q == lbbe_pkg::PLANE_W'(lbbe_pkg::PLANES_OUT - 1));
	assign last_word = plane_end && ((head.mode != lbbe_pkg::OP_BAR32) || half_q);
	assign pop       = adv && last_word;

	// Each LED of the current column maps to one bar position, or is dark.
	always_comb begin
		logic                          active;
		logic [lbbe_pkg::POS_W-1:0]    pos;
		logic [lbbe_pkg::CODE_W-1:0]   code;
		word = '0;
		for (int j = 0; j < lbbe_pkg::WORD_W; j++) begin
			active = 1'b1;
			pos    = '0;
			unique case (head.mode)
				lbbe_pkg::OP_BAR16: begin
					pos = lbbe_pkg::POS_W'(15 - j);
				end
				lbbe_pkg::OP_SIGNED16: begin
					if (head.neg) begin
						active = (j >= 8);
						pos    = lbbe_pkg::POS_W'(j - 8);
					end else begin
						active = (j < 8);
						pos    = lbbe_pkg::POS_W'(7 - j);
					end
				end
				lbbe_pkg::OP_BAR32: begin
					// The second column shows the even positions, unless both
					// columns are the same one.
					pos = (half_q && !head.same) ? lbbe_pkg::POS_W'(2 * j)
						: lbbe_pkg::POS_W'(2 * j + 1);
				end
				default: begin
					active = 1'b0;
				end
			endcase
			code = active ? lbbe_pkg::bar_code(levels, head.coarse, head.step, pos)
				: levels.off;
			word[j] = code[plane_q];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			o_column_q <= half_q ? head.col_second : head.col_first;
			o_plane_q  <= plane_q;
			o_word_q   <= word;
			o_last_q   <= last_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			plane_q   <= '0;
			half_q    <= 1'b0;
		end else begin
			if (adv) begin
				o_valid_q <= 1'b1;
			end else if (words.ready) begin
				o_valid_q <= 1'b0;
			end
			if (adv) begin
				if (plane_end) begin
					plane_q <= '0;
					half_q  <= !last_word;
				end else begin
					plane_q <= plane_q + 1'b1;
				end
			end
		end
	end

	assign words.valid      = o_valid_q;
	assign words.column     = o_column_q;
	assign words.plane      = o_plane_q;
	assign words.plane_word = o_word_q;
	assign words.last       = o_last_q;

	`LBBE_ASSERT_IMPL(a_last_plane, o_valid_q && o_last_q, o_plane_q == lbbe_pkg::PLANE_W'(lbbe_pkg::PLANES_OUT - 1), "last word on an inner plane")
	`LBBE_ASSERT_IMPL(a_half_mode, half_q && nonempty, head.mode == lbbe_pkg::OP_BAR32, "second column outside 32-LED mode")

endmodule

[rtl/led_bar_bitplane_encoder_unit.sv]
// ----------------------------------------------------------------------------
// LED bar bit-plane encoder
// Turns an 8-bit level into a bar of LED intensity codes and sends it out as
// bit-plane words for binary code modulation.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                          | words
//  items    | in  | opcode, bar_value, column_first, column_second   | 1 per request
//  words    | out | column, plane, plane_word, last                  | 4 or 8 per request
//  cfg      | in  | cfg_we, cfg_index, cfg_data (no read-back)       | 1 per register
//
// A 16-LED request leaves as four plane words, a 32-LED request as eight, one word
// per cycle unless stalled; the single word-building stage in the back sets it.
// The front takes a new request in any cycle in which the two-entry job queue
// has room, so requests follow each other with no gap while words still drain.
// A request with the unused opcode is taken and produces no word.
// Reset clears the queue, the back-end counters and the output valid, and
// loads the intensity registers with their default codes.
// A stalled output holds its word; the back then stops and the queue fills.
// ----------------------------------------------------------------------------
module led_bar_bitplane_encoder_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lbbe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lbbe_pkg::CFG_W-1:0]     cfg_data,
	lbbe_in_if.sink                        items,
	lbbe_out_if.source                     words
);

	// Intensity codes used by the back end for every LED.
	lbbe_pkg::levels_t levels_q;

	logic              full;
	logic              push;
	lbbe_pkg::job_t    push_job;
	logic              pop;
	logic              nonempty;
	lbbe_pkg::job_t    head;

	// Register writes must only come while no word is in flight; the block does not
	// enforce this, and the back end reads the codes directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q.off      <= lbbe_pkg::RST_LEVEL_OFF;
			levels_q.low      <= lbbe_pkg::RST_LEVEL_LOW;
			levels_q.low_mid  <= lbbe_pkg::RST_LEVEL_LOW_MID;
			levels_q.high_mid <= lbbe_pkg::RST_LEVEL_HIGH_MID;
			levels_q.full     <= lbbe_pkg::RST_LEVEL_FULL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbbe_pkg::CFG_LEVEL_OFF:      levels_q.off      <= cfg_data;
				lbbe_pkg::CFG_LEVEL_LOW:      levels_q.low      <= cfg_data;
				lbbe_pkg::CFG_LEVEL_LOW_MID:  levels_q.low_mid  <= cfg_data;
				lbbe_pkg::CFG_LEVEL_HIGH_MID: levels_q.high_mid <= cfg_data;
				lbbe_pkg::CFG_LEVEL_FULL:     levels_q.full     <= cfg_data;
				default:                      levels_q          <= levels_q;
			endcase
		end
	end

	// The front classifies each request and reduces the level.
	lbbe_front u_front (
		.items (items),
		.full  (full),
		.push  (push),
		.job   (push_job)
	);

	// The queue decouples acceptance from word generation.
	lbbe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (full),
		.nonempty (nonempty),
		.head     (head)
	);

	// The back walks planes and columns of the head job.
	lbbe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.levels   (levels_q),
		.nonempty (nonempty),
		.head     (head),
		.pop      (pop),
		.words    (words)
	);

endmodule

[tb/bitplane_word_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Plane word checker
// Watches the request and plane word channels and keeps a private copy of the
// intensity registers. It predicts the plane words of every accepted request
// and compares each delivered word, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module bitplane_word_checker
	import lbbe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	lbbe_in_if                   items,
	lbbe_out_if                  words,
	output int                   words_due,
	output int                   mismatches
);

	typedef struct packed {
		logic [COL_W-1:0]   column;
		logic [PLANE_W-1:0] plane;
		logic [WORD_W-1:0]  bits;
		logic               last;
	} plane_word_t;

	typedef logic [CODE_W-1:0] led_codes_t [16];

	levels_t     levels;
	plane_word_t expected_words [$];

	// LEDs below the coarse position are full, those above are off, and the
	// one at the coarse position shows the partial step.
	function automatic logic [CODE_W-1:0] intensity_at(input levels_t lv, input int coarse,
		input int step, input int pos);
		logic [CODE_W-1:0] code;
		if (pos < coarse) begin
			code = lv.full;
		end else if (pos > coarse) begin
			code = lv.off;
		end else begin
			case (step)
				0:       code = lv.off;
				1:       code = lv.low;
				2:       code = lv.low_mid;
				default: code = lv.high_mid;
			endcase
		end
		return code;
	endfunction

	// Transposes the sixteen codes of one column into its plane words.
	task automatic push_column(input led_codes_t codes, input logic [COL_W-1:0] col,
		input logic closes);
		plane_word_t w;
		for (int p = 0; p < PLANES_OUT; p++) begin
			w.column = col;
			w.plane  = PLANE_W'(p);
			w.bits   = '0;
			for (int i = 0; i < 16; i++)
				w.bits[i] = codes[i][p];
			w.last = closes && (p == PLANES_OUT - 1);
			expected_words.push_back(w);
		end
	endtask

	task automatic predict_request(input opcode_t op, input logic [VAL_W-1:0] v,
		input logic [COL_W-1:0] c1, input logic [COL_W-1:0] c2);
		led_codes_t       odd_leds;
		led_codes_t       even_leds;
		logic [MAG_W-1:0] mag;
		case (op)
			OP_BAR16: begin
				for (int pos = 0; pos < 16; pos++)
					odd_leds[15 - pos] = intensity_at(levels, v[7:4], v[3:2], pos);
				push_column(odd_leds, c1, 1'b1);
			end
			OP_SIGNED16: begin
				mag = v[7] ? (MAG_W'(256) - MAG_W'(v)) : MAG_W'(v);
				for (int i = 0; i < 16; i++)
					odd_leds[i] = levels.off;
				if (v != '0) begin
					for (int pos = 0; pos < 8; pos++) begin
						if (v[7])
							odd_leds[8 + pos] = intensity_at(levels, mag[8:4], mag[3:2], pos);
						else
							odd_leds[7 - pos] = intensity_at(levels, mag[8:4], mag[3:2], pos);
					end
				end
				push_column(odd_leds, c1, 1'b1);
			end
			OP_BAR32: begin
				for (int pos = 0; pos < 32; pos++) begin
					if (pos % 2 == 1)
						odd_leds[pos / 2] = intensity_at(levels, v[7:3], v[2:1], pos);
					else
						even_leds[pos / 2] = intensity_at(levels, v[7:3], v[2:1], pos);
				end
				push_column(odd_leds, c1, 1'b0);
				// On a shared column the odd LEDs win.
				if (c1 == c2)
					push_column(odd_leds, c2, 1'b1);
				else
					push_column(even_leds, c2, 1'b1);
			end
			default: ;
		endcase
	endtask

	task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
		input logic [WORD_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		plane_word_t want;
		if (!arst_n) begin
			levels = '{off: RST_LEVEL_OFF, low: RST_LEVEL_LOW, low_mid: RST_LEVEL_LOW_MID,
				high_mid: RST_LEVEL_HIGH_MID, full: RST_LEVEL_FULL};
			expected_words.delete();
			mismatches = 0;
			words_due <= 0;
		end else begin
			if (items.valid && items.ready)
				predict_request(opcode_t'(items.opcode), items.bar_value, items.column_first,
					items.column_second);
			if (words.valid && words.ready) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word, expected none, actual col %h plane %h %h last %b",
						$realtime, words.column, words.plane, words.plane_word, words.last);
				end else begin
					want = expected_words.pop_front();
					compare_field("column", WORD_W'(want.column), WORD_W'(words.column));
					compare_field("plane", WORD_W'(want.plane), WORD_W'(words.plane));
					compare_field("plane_word", want.bits, words.plane_word);
					compare_field("last", WORD_W'(want.last), WORD_W'(words.last));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_LEVEL_OFF:      levels.off      = cfg_data;
					CFG_LEVEL_LOW:      levels.low      = cfg_data;
					CFG_LEVEL_LOW_MID:  levels.low_mid  = cfg_data;
					CFG_LEVEL_HIGH_MID: levels.high_mid = cfg_data;
					CFG_LEVEL_FULL:     levels.full     = cfg_data;
					default: ;
				endcase
			end
			words_due <= expected_words.size();
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED bar bit-plane encoder testbench
// Drives bar requests into the encoder with random gaps, stalls the plane word
// output at random, and reloads the intensity registers between phases. A
// checker beside the encoder predicts and compares every plane word; this
// module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import lbbe_pkg::*;

	// Cycles to let pass after the last expected word before the registers
	// are touched. Requests with the unused opcode never enter the job queue,
	// so this is only a margin on top of the drain.
	localparam int SETTLE_CYCLES = 32;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   words_due;
	int                   mismatches;
	// While set, neither the sender nor the receiver idles.
	bit                   calm;

	lbbe_in_if  items_ch ();
	lbbe_out_if words_ch ();

	led_bar_bitplane_encoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (items_ch),
		.words     (words_ch)
	);

	bitplane_word_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.items      (items_ch),
		.words      (words_ch),
		.words_due  (words_due),
		.mismatches (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The slowest correct run stays well under half a millisecond, so this
	// only fires when the encoder hangs or stops delivering words.
	initial begin
		#(5_000_000);
		$display("testbench NOT OK");
		$finish;
	end

	// Receiver: before every word it draws a stall, holds ready low for that
	// many cycles, then keeps ready high until a word is taken. Ready is never
	// lowered and raised in the same step, so a zero stall keeps it high.
	initial begin
		int stall;
		words_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				words_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			words_ch.ready <= 1'b1;
			do @(posedge clk); while (words_ch.valid !== 1'b1);
		end
	end

	// Offers one request word after a random gap and returns at the edge
	// where it is taken. Valid stays high when the next word follows with no
	// gap, so it only drops when a gap is actually drawn.
	task automatic send_request(input opcode_t op, input logic [VAL_W-1:0] v,
		input logic [COL_W-1:0] c1, input logic [COL_W-1:0] c2);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_ch.valid         <= 1'b1;
		items_ch.opcode        <= op;
		items_ch.bar_value     <= v;
		items_ch.column_first  <= c1;
		items_ch.column_second <= c2;
		do @(posedge clk); while (items_ch.ready !== 1'b1);
	endtask

	// Stops sending and waits until every predicted word has come out, then
	// leaves the encoder time to finish anything that produces no word.
	task automatic wait_idle();
		items_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all five intensity registers, one per cycle.
	task automatic load_levels(input levels_t lv);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LEVEL_OFF;
		cfg_data  <= lv.off;
		@(posedge clk);
		cfg_index <= CFG_LEVEL_LOW;
		cfg_data  <= lv.low;
		@(posedge clk);
		cfg_index <= CFG_LEVEL_LOW_MID;
		cfg_data  <= lv.low_mid;
		@(posedge clk);
		cfg_index <= CFG_LEVEL_HIGH_MID;
		cfg_data  <= lv.high_mid;
		@(posedge clk);
		cfg_index <= CFG_LEVEL_FULL;
		cfg_data  <= lv.full;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Bar levels lean toward the ends of the range and the signed extremes.
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			default: return VAL_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly real columns, now and then one past the display.
	function automatic logic [COL_W-1:0] pick_column();
		if ($urandom_range(0, 7) == 0)
			return COL_W'($urandom_range(10, 15));
		return COL_W'($urandom_range(0, 9));
	endfunction

	// One phase: quiesce, load a level set, then send random requests. Words
	// with the unused opcode are mixed in but not counted.
	task automatic run_phase(input levels_t lv, input bit quiet, input int count);
		int               sent;
		opcode_t          op;
		logic [COL_W-1:0] c1;
		logic [COL_W-1:0] c2;
		wait_idle();
		load_levels(lv);
		calm = quiet;
		sent = 0;
		while (sent < count) begin
			op = ($urandom_range(0, 39) == 0) ? OP_NONE : opcode_t'($urandom_range(0, 2));
			c1 = pick_column();
			c2 = ($urandom_range(0, 5) == 0) ? c1 : pick_column();
			send_request(op, pick_value(), c1, c2);
			if (op != OP_NONE)
				sent++;
		end
	endtask

	initial begin
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= CFG_LEVEL_OFF;
		cfg_data               <= '0;
		items_ch.valid         <= 1'b0;
		items_ch.opcode        <= OP_BAR16;
		items_ch.bar_value     <= '0;
		items_ch.column_first  <= '0;
		items_ch.column_second <= '0;
		calm = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words with the reset levels. The 16-LED bar: empty, full,
		// the highest partial step with no full LED, each partial step on the
		// second LED, and a column past the display with a stray second column.
		send_request(OP_BAR16, 8'h00, 4'd0, 4'd0);
		send_request(OP_BAR16, 8'hFF, 4'd9, 4'd15);
		send_request(OP_BAR16, 8'h0F, 4'd5, 4'd0);
		send_request(OP_BAR16, 8'h10, 4'd1, 4'd7);
		send_request(OP_BAR16, 8'h14, 4'd2, 4'd0);
		send_request(OP_BAR16, 8'h18, 4'd3, 4'd0);
		send_request(OP_BAR16, 8'h1C, 4'd4, 4'd0);
		send_request(OP_BAR16, 8'hF3, 4'd15, 4'd10);
		// The signed bar: zero turns everything off, the largest positive,
		// minus 128 lighting the whole lower half, one above it, minus one,
		// plus one, and a mirrored pair of partial steps.
		send_request(OP_SIGNED16, 8'h00, 4'd2, 4'd0);
		send_request(OP_SIGNED16, 8'h7F, 4'd3, 4'd15);
		send_request(OP_SIGNED16, 8'h80, 4'd4, 4'd0);
		send_request(OP_SIGNED16, 8'h81, 4'd5, 4'd0);
		send_request(OP_SIGNED16, 8'hFF, 4'd6, 4'd0);
		send_request(OP_SIGNED16, 8'h01, 4'd7, 4'd0);
		send_request(OP_SIGNED16, 8'h14, 4'd8, 4'd0);
		send_request(OP_SIGNED16, 8'hEC, 4'd9, 4'd0);
		send_request(OP_SIGNED16, 8'h0C, 4'd11, 4'd0);
		// The 32-LED bar over two columns, including one column named twice
		// and two columns past the display.
		send_request(OP_BAR32, 8'h00, 4'd0, 4'd1);
		send_request(OP_BAR32, 8'hFF, 4'd9, 4'd8);
		send_request(OP_BAR32, 8'h07, 4'd2, 4'd3);
		send_request(OP_BAR32, 8'h0A, 4'd4, 4'd5);
		send_request(OP_BAR32, 8'h0C, 4'd1, 4'd0);
		send_request(OP_BAR32, 8'h0E, 4'd6, 4'd6);
		send_request(OP_BAR32, 8'h5B, 4'd12, 4'd10);
		// The unused opcode must produce nothing at all.
		send_request(OP_NONE, 8'hFF, 4'd15, 4'd15);

		// Random phases, each behind a full drain: all codes zero, all codes
		// full, an inverted set, then random sets. Two phases run without any
		// idling on either side so words go back to back.
		run_phase(levels_t'(20'h00000), 1'b0, 30);
		run_phase(levels_t'(20'hFFFFF), 1'b0, 30);
		run_phase('{off: 4'hF, low: 4'h0, low_mid: 4'hF, high_mid: 4'h0, full: 4'h0}, 1'b1, 30);
		run_phase(levels_t'(20'($urandom())), 1'b0, 35);
		run_phase(levels_t'(20'($urandom())), 1'b1, 35);
		run_phase(levels_t'(20'($urandom())), 1'b0, 35);
		run_phase(levels_t'(20'($urandom())), 1'b0, 35);

		wait_idle();
		if (mismatches == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
